@@ hw/rtl/ftc32_pkg.sv @@
// ----------------------------------------------------------------------------
// ftc32_pkg
// Shared types, codes and round primitives of the 32-bit toy Feistel cipher:
// nibble S-box, 16-bit bit permutation, key schedule constant, sequencer states.
// ----------------------------------------------------------------------------
package ftc32_pkg;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DERIVE,
		ST_ROUND,
		ST_DONE
	} ftc32_state_t;

	// Opcodes: bit 1 set selects decryption with the raw master key
	localparam logic [1:0] OP_ENCRYPT     = 2'd0;
	localparam logic [1:0] OP_DEC_DERIVED = 2'd1;
	localparam int         OP_RAW_BIT     = 1;

	// Configuration register indexes
	localparam logic CFG_MASTER_KEY  = 1'b0;
	localparam logic CFG_ROUND_COUNT = 1'b1;

	localparam logic [15:0] KEY_CONST   = 16'h000C;
	localparam int          MIN_ROUNDS  = 4;
	localparam logic [5:0]  RESET_ROUNDS = 6'd16;

	typedef logic [3:0][15:0] ftc32_window_t;

	function automatic logic [3:0] sbox4(input logic [3:0] n);
		logic [3:0] r;
		unique case (n)
			4'h0: r = 4'hE;
			4'h1: r = 4'hB;
			4'h2: r = 4'h4;
			4'h3: r = 4'h6;
			4'h4: r = 4'hA;
			4'h5: r = 4'hD;
			4'h6: r = 4'h7;
			4'h7: r = 4'h0;
			4'h8: r = 4'h3;
			4'h9: r = 4'h8;
			4'hA: r = 4'hF;
			4'hB: r = 4'hC;
			4'hC: r = 4'h5;
			4'hD: r = 4'h9;
			4'hE: r = 4'h1;
			default: r = 4'h2;
		endcase
		return r;
	endfunction

	function automatic logic [15:0] subst16(input logic [15:0] w);
		return {sbox4(w[15:12]), sbox4(w[11:8]), sbox4(w[7:4]), sbox4(w[3:0])};
	endfunction

	function automatic logic [15:0] perm16(input logic [15:0] x);
		return ((x & 16'hC00C) >> 1) |
		       ((x & 16'h2000) >> 6) |
		       ((x & 16'h1000) >> 8) |
		       ((x & 16'h0C00) >> 5) |
		       ((x & 16'h0200) << 6) |
		       ((x & 16'h0100) << 4) |
		       ((x & 16'h00C0) << 3) |
		       ((x & 16'h0020) >> 2) |
		       ((x & 16'h0010) >> 4) |
		       ((x & 16'h0002) << 10) |
		       ((x & 16'h0001) << 8);
	endfunction

endpackage

@@ hw/rtl/ftc32_in_if.sv @@
// ----------------------------------------------------------------------------
// ftc32_in_if
// Request channel of the cipher: opcode and 32-bit block under valid/ready.
// ----------------------------------------------------------------------------
interface ftc32_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [31:0] data_in;

	modport source (output valid, output opcode, output data_in, input ready);
	modport sink   (input valid, input opcode, input data_in, output ready);
endinterface

@@ hw/rtl/ftc32_out_if.sv @@
// ----------------------------------------------------------------------------
// ftc32_out_if
// Result channel of the cipher: 32-bit block under valid/ready.
// ----------------------------------------------------------------------------
interface ftc32_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] data_out;

	modport source (output valid, output data_out, input ready);
	modport sink   (input valid, input data_out, output ready);
endinterface

@@ hw/rtl/ftc32_unit.sv @@
// ----------------------------------------------------------------------------
// ftc32_unit
// Shared round datapath: one Feistel round function on the left half and
// one step of the key recurrence (forward or inverse) on the key window.
// ----------------------------------------------------------------------------
module ftc32_unit
	import ftc32_pkg::*;
(
	input  logic [15:0]   left,
	input  logic [15:0]   right,
	input  ftc32_window_t win,
	input  logic          inverse,
	output logic [15:0]   new_left,
	output logic [15:0]   new_key
);

	// Round: substitute, permute, mix in right half and current key word
	assign new_left = perm16(subst16(left)) ^ right ^ win[0];

	// Key step: forward uses the newest word, inverse the second oldest
	assign new_key = win[0] ^ (inverse ? win[1] : win[3]) ^ perm16(win[2]) ^ KEY_CONST;

endmodule

@@ hw/rtl/feistel_toy_cipher_32.sv @@
// ----------------------------------------------------------------------------
// feistel_toy_cipher_32
// 32-bit block Feistel cipher with on-the-fly 16-bit key schedule.
// ----------------------------------------------------------------------------
// One request is processed at a time by a single round unit under a small
// sequencer. An encryption or a raw-key decryption (R = round count, 16
// after reset) is accepted, runs one round per cycle for R rounds, and then
// writes the result register once it is free or being drained. The
// first derived-key decryption after reset or after any configuration write
// first runs the forward key schedule for R - 4 steps and then latches the
// key; later ones reuse the cached key.
// A new request is taken once the sequencer is back in idle, even while the
// previous result still waits in the output register. Round counts below 4
// act as 4, those above MAX_ROUNDS as MAX_ROUNDS.
// ----------------------------------------------------------------------------
module feistel_toy_cipher_32
	import ftc32_pkg::*;
#(
	parameter int MAX_ROUNDS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	ftc32_in_if.sink           blk_in,
	ftc32_out_if.source        blk_out,
	input  logic               cfg_we,
	input  logic               cfg_idx,
	input  logic [63:0]        cfg_wdata
);

	localparam int CW = $clog2(MAX_ROUNDS + 1);
	localparam logic [6:0]    MAX_R7  = 7'(MAX_ROUNDS);
	localparam logic [CW-1:0] MAX_R   = CW'(MAX_ROUNDS);
	localparam logic [CW-1:0] MIN_R   = CW'(MIN_ROUNDS);

	ftc32_state_t  state_q, state_d;
	logic [63:0]   master_key_q;
	logic [5:0]    round_count_q;
	logic [63:0]   dk_q;
	logic          dk_valid_q;
	ftc32_window_t win_q;
	logic [15:0]   left_q, right_q;
	logic [CW-1:0] cnt_q;
	logic          dec_q;
	logic          out_valid_q;
	logic [31:0]   out_data_q;

	logic [CW-1:0] eff_rounds;
	logic          in_take, out_load, derive_end, round_end, cfg_key_write;
	logic          unit_inv;
	logic [15:0]   new_left, new_key;

	// Saturate round count into the supported range
	always_comb begin
		if (round_count_q < 6'(MIN_ROUNDS)) begin
			eff_rounds = MIN_R;
		end else if ({1'b0, round_count_q} > MAX_R7) begin
			eff_rounds = MAX_R;
		end else begin
			eff_rounds = CW'(round_count_q);
		end
	end

	// Run the forward schedule while deriving the cached key
	assign unit_inv = dec_q && (state_q != ST_DERIVE);

	ftc32_unit u_unit (
		.left     (left_q),
		.right    (right_q),
		.win      (win_q),
		.inverse  (unit_inv),
		.new_left (new_left),
		.new_key  (new_key)
	);

	assign derive_end    = (cnt_q == CW'(eff_rounds - MIN_R));
	assign round_end     = (cnt_q == CW'(eff_rounds - CW'(1)));
	assign cfg_key_write = cfg_we && (cfg_idx == CFG_MASTER_KEY || cfg_idx == CFG_ROUND_COUNT);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_take) begin
					if (blk_in.opcode == OP_DEC_DERIVED && !dk_valid_q) begin
						state_d = ST_DERIVE;
					end else begin
						state_d = ST_ROUND;
					end
				end
			end
			ST_DERIVE: begin
				if (derive_end) state_d = ST_ROUND;
			end
			ST_ROUND: begin
				if (round_end) state_d = ST_DONE;
			end
			default: begin
				if (out_load) state_d = ST_IDLE;
			end
		endcase
	end

	// Handshake outputs
	always_comb begin
		blk_in.ready = (state_q == ST_IDLE);
		in_take      = blk_in.valid && (state_q == ST_IDLE);
		out_load     = (state_q == ST_DONE) && (!out_valid_q || blk_out.ready);
	end

	assign blk_out.valid    = out_valid_q;
	assign blk_out.data_out = out_data_q;

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			master_key_q  <= '0;
			round_count_q <= RESET_ROUNDS;
			dk_valid_q    <= 1'b0;
			out_valid_q   <= 1'b0;
			cnt_q         <= '0;
		end else begin
			state_q <= state_d;

			// Configuration writes; any write drops the cached key
			if (cfg_we && cfg_idx == CFG_MASTER_KEY) master_key_q <= cfg_wdata;
			if (cfg_we && cfg_idx == CFG_ROUND_COUNT) round_count_q <= cfg_wdata[5:0];
			if (cfg_key_write) begin
				dk_valid_q <= 1'b0;
			end else if (state_q == ST_DERIVE && derive_end) begin
				dk_valid_q <= 1'b1;
			end

			// Step counter
			if (in_take || (state_q == ST_DERIVE && derive_end)) begin
				cnt_q <= '0;
			end else if (state_q == ST_DERIVE || state_q == ST_ROUND) begin
				cnt_q <= cnt_q + CW'(1);
			end

			// Result register valid
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (blk_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_take) begin
					dec_q <= (blk_in.opcode != OP_ENCRYPT);
					if (blk_in.opcode == OP_ENCRYPT) begin
						left_q  <= blk_in.data_in[31:16];
						right_q <= blk_in.data_in[15:0];
						win_q   <= {master_key_q[15:0], master_key_q[31:16],
						            master_key_q[47:32], master_key_q[63:48]};
					end else begin
						left_q  <= blk_in.data_in[15:0];
						right_q <= blk_in.data_in[31:16];
						if (blk_in.opcode[OP_RAW_BIT]) begin
							win_q <= master_key_q;
						end else if (dk_valid_q) begin
							win_q <= dk_q;
						end else begin
							win_q <= {master_key_q[15:0], master_key_q[31:16],
							          master_key_q[47:32], master_key_q[63:48]};
						end
					end
				end
			end
			ST_DERIVE: begin
				if (derive_end) begin
					// Cache the last four forward keys, seed the inverse schedule
					dk_q  <= {win_q[0], win_q[1], win_q[2], win_q[3]};
					win_q <= {win_q[0], win_q[1], win_q[2], win_q[3]};
				end else begin
					win_q <= {new_key, win_q[3], win_q[2], win_q[1]};
				end
			end
			ST_ROUND: begin
				left_q  <= new_left;
				right_q <= left_q;
				win_q   <= {new_key, win_q[3], win_q[2], win_q[1]};
			end
			default: begin
				if (out_load) begin
					out_data_q <= dec_q ? {right_q, left_q} : {left_q, right_q};
				end
			end
		endcase
	end

	// Derivation runs only when no cached key exists
	a_derive_uncached: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DERIVE |-> !dk_valid_q)
		else $error("key derivation with a valid cached key");

	// Round counter stays below the round count
	a_round_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ROUND |-> cnt_q < eff_rounds)
		else $error("round counter past round count");

	// An accepted request leaves idle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		blk_in.valid && blk_in.ready |=> state_q != ST_IDLE)
		else $error("request accepted without starting");

	// Configuration write drops the cached key
	a_cfg_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_key_write |=> !dk_valid_q)
		else $error("cached key survived a configuration write");

	// Result register is written only when free or being drained
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> !out_valid_q || blk_out.ready)
		else $error("pending result overwritten");

endmodule
